### src/key_debounce_autorepeat_core_assert.svh
// Assertion macros for the key debounce and auto-repeat core.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef KEY_DEBOUNCE_AUTOREPEAT_CORE_ASSERT_SVH
`define KEY_DEBOUNCE_AUTOREPEAT_CORE_ASSERT_SVH

// antecedent holds, consequent follows on the next edge
`define KDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// antecedent holds, consequent holds on the same edge
`define KDA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### src/kda_pkg.sv
// Package for the key debounce and auto-repeat core: phase type and
// configuration register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kda_pkg;

  // poll phase
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HELD     = 2'd2
  } phase_t;

  localparam int unsigned CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t REG_DEBOUNCE = 2'd0;
  localparam cfg_idx_t REG_HOLD     = 2'd1;
  localparam cfg_idx_t REG_REPEAT   = 2'd2;

  localparam logic [15:0] DEBOUNCE_RST = 16'd50;
  localparam logic [15:0] HOLD_RST     = 16'd1000;
  localparam logic [15:0] REPEAT_RST   = 16'd200;

endpackage

`default_nettype wire

### src/key_debounce_autorepeat_core.sv
// Key debounce and auto-repeat core, top level.
// Depends on kda_pkg and key_debounce_autorepeat_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

// One poll word (timestamp, key sample, repeat mode) is taken every clock
// cycle; its key_event word passes through an input register and then a
// result register, with all phase logic in between the two.
// The single state update per cycle (two 32-bit wrapping subtractions and
// their compares) sets the figure of one word per cycle. Both stages stall
// only when the result is not taken. Configuration writes are taken every
// cycle (cfg_ready is always high); writes to index 3 are ignored.
`include "key_debounce_autorepeat_core_assert.svh"

module key_debounce_autorepeat_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // poll channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [31:0]           in_now_ms,
  input  wire logic [3:0]            in_key_sample,
  input  wire logic                  in_repeat_mode,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [3:0]                 out_key_event,
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire kda_pkg::cfg_idx_t     cfg_index,
  input  wire logic [15:0]           cfg_data
);

  // configuration registers
  logic [15:0] debounce_ms_r;
  logic [15:0] hold_ms_r;
  logic [15:0] repeat_ms_r;

  // input stage
  logic        s1_valid_r;
  logic [31:0] s1_now_r;
  logic [3:0]  s1_key_r;
  logic        s1_mode_r;

  // result stage
  logic        out_valid_r;
  logic [3:0]  out_key_r;

  // phase state
  kda_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  held_key_r, held_key_nxt;
  logic [31:0] press_time_r, press_time_nxt;
  logic        repeat_pending_r, repeat_pending_nxt;
  logic [31:0] repeat_time_r, repeat_time_nxt;
  logic [3:0]  event_nxt;

  logic        advance;
  logic [31:0] since_press;
  logic [31:0] since_repeat;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r <= kda_pkg::DEBOUNCE_RST;
      hold_ms_r     <= kda_pkg::HOLD_RST;
      repeat_ms_r   <= kda_pkg::REPEAT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        kda_pkg::REG_DEBOUNCE: debounce_ms_r <= cfg_data;
        kda_pkg::REG_HOLD:     hold_ms_r     <= cfg_data;
        kda_pkg::REG_REPEAT:   repeat_ms_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: the word in stage 1 moves on when the result slot is free
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_now_r  <= in_now_ms;
      s1_key_r  <= in_key_sample;
      s1_mode_r <= in_repeat_mode;
    end
  end

  // wrapping elapsed times
  assign since_press  = s1_now_r - press_time_r;
  assign since_repeat = s1_now_r - repeat_time_r;

  // phase state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= kda_pkg::PH_IDLE;
      held_key_r       <= 4'd0;
      press_time_r     <= 32'd0;
      repeat_pending_r <= 1'b0;
      repeat_time_r    <= 32'd0;
    end else if (advance) begin
      phase_r          <= phase_nxt;
      held_key_r       <= held_key_nxt;
      press_time_r     <= press_time_nxt;
      repeat_pending_r <= repeat_pending_nxt;
      repeat_time_r    <= repeat_time_nxt;
    end
  end

  // next phase and reported key
  always_comb begin
    phase_nxt          = phase_r;
    held_key_nxt       = held_key_r;
    press_time_nxt     = press_time_r;
    repeat_pending_nxt = repeat_pending_r;
    repeat_time_nxt    = repeat_time_r;
    event_nxt          = 4'd0;
    unique case (phase_r)
      kda_pkg::PH_IDLE: begin
        if (s1_key_r != 4'd0) begin
          phase_nxt      = kda_pkg::PH_DEBOUNCE;
          held_key_nxt   = s1_key_r;
          press_time_nxt = s1_now_r;
        end
      end
      kda_pkg::PH_DEBOUNCE: begin
        if (since_press >= {16'd0, debounce_ms_r}) begin
          if (s1_key_r != held_key_r) begin
            phase_nxt    = kda_pkg::PH_IDLE;
            held_key_nxt = 4'd0;
          end else begin
            phase_nxt = kda_pkg::PH_HELD;
            event_nxt = s1_key_r;
          end
        end
      end
      kda_pkg::PH_HELD: begin
        // any change of sample is a release; the repeat flag is kept
        if (s1_key_r != held_key_r) begin
          phase_nxt    = kda_pkg::PH_IDLE;
          held_key_nxt = 4'd0;
        end else if (s1_mode_r && (since_press >= {16'd0, hold_ms_r})) begin
          if (!repeat_pending_r) begin
            repeat_pending_nxt = 1'b1;
            repeat_time_nxt    = s1_now_r;
            event_nxt          = s1_key_r;
          end else if (since_repeat > {16'd0, repeat_ms_r}) begin
            repeat_pending_nxt = 1'b0;
          end
        end
      end
      default: begin
        phase_nxt    = kda_pkg::PH_IDLE;
        held_key_nxt = 4'd0;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_key_r <= event_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_key_event = out_key_r;

  // checks
  `KDA_ASSERT_NEXT(a_idle_press,
    advance && (phase_r == kda_pkg::PH_IDLE) && (s1_key_r != 4'd0),
    (phase_r == kda_pkg::PH_DEBOUNCE) && (held_key_r == $past(s1_key_r)),
    "press in idle did not start debounce")
  `KDA_ASSERT_SAME(a_event_phase, advance && (event_nxt != 4'd0),
    (phase_r == kda_pkg::PH_DEBOUNCE) || (phase_r == kda_pkg::PH_HELD),
    "key reported outside debounce or held phase")
  `KDA_ASSERT_SAME(a_key_idle, 1'b1,
    (phase_r == kda_pkg::PH_IDLE) == (held_key_r == 4'd0),
    "held key and idle phase disagree")
  `KDA_ASSERT_NEXT(a_s1_hold, s1_valid_r && !advance, s1_valid_r,
    "stalled poll word dropped from input stage")
  `KDA_ASSERT_SAME(a_out_rise, $rose(out_valid_r), $past(advance),
    "result appeared without a poll word moving on")

endmodule

`default_nettype wire
